@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

@@ src/mge_pkg.sv @@
// Types and constants of the max-gradient edge-to-symbol block
package mge_pkg;

   localparam int IMAGE_WIDTH_BITS = 11;
   localparam int GREY_LEVELS_BITS = 3;
   localparam int PIXEL_BITS       = 8;
   localparam int SYMBOL_BITS      = 7;
   localparam int LEVEL_BITS       = 2;
   localparam int CSR_INDEX_BITS   = 2;

   localparam logic [GREY_LEVELS_BITS-1:0] GREY_LEVELS_RESET = 3'd2;
   localparam logic [IMAGE_WIDTH_BITS-1:0] IMAGE_WIDTH_RESET = 11'd640;
   localparam logic [GREY_LEVELS_BITS-1:0] GREY_LEVELS_MIN   = 3'd1;
   localparam logic [GREY_LEVELS_BITS-1:0] GREY_LEVELS_MAX   = 3'd4;

   localparam logic [SYMBOL_BITS-1:0] SYM_SPACE = 7'h20;
   localparam logic [SYMBOL_BITS-1:0] SYM_DOT   = 7'h2E;
   localparam logic [SYMBOL_BITS-1:0] SYM_COLON = 7'h3A;
   localparam logic [SYMBOL_BITS-1:0] SYM_HASH  = 7'h23;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GREY_LEVELS = 2'd0,
      CSR_IMAGE_WIDTH = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  frame_start;
   } req_type;

   typedef struct packed {
      logic [SYMBOL_BITS-1:0] symbol;
      logic                   row_end;
   } rsp_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] upper_left;
      logic [LEVEL_BITS-1:0] upper_right;
      logic [LEVEL_BITS-1:0] lower_left;
      logic [LEVEL_BITS-1:0] lower_right;
   } window_type;

endpackage

@@ src/mge_line_ram.sv @@
// Read-first line buffer RAM with registered read data
module mge_line_ram #(
   parameter int DEPTH      = 1024,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [ADDR_WIDTH-1:0]          addr,
   input  logic [mge_pkg::LEVEL_BITS-1:0] wr_data,
   output logic [mge_pkg::LEVEL_BITS-1:0] rd_data
);

   logic [mge_pkg::LEVEL_BITS-1:0] mem [DEPTH];
   logic [mge_pkg::LEVEL_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/mge_grad_core.sv @@
// Four-gradient maximum over a 2x2 window and symbol lookup
module mge_grad_core (
   input  mge_pkg::window_type                     window,
   input  logic [mge_pkg::GREY_LEVELS_BITS-1:0]    levels,
   output logic [mge_pkg::SYMBOL_BITS-1:0]         symbol
);

   function automatic logic [2:0] abs4(input logic signed [3:0] v);
      logic signed [3:0] n;
      n = -v;
      return v[3] ? n[2:0] : v[2:0];
   endfunction

   logic signed [3:0] p1, p2, p3, p4;
   logic signed [3:0] sum_h, sum_v, sum_d, sum_a;
   logic [2:0] abs_h, abs_v, abs_d, abs_a;
   logic [1:0] g_h, g_v, g_d, g_a, g_hv, g_da, g_max;

   always_comb begin
      p1 = signed'({2'b00, window.upper_left});
      p2 = signed'({2'b00, window.upper_right});
      p3 = signed'({2'b00, window.lower_left});
      p4 = signed'({2'b00, window.lower_right});
      sum_h = p1 - p2 + p3 - p4;
      sum_v = p1 + p2 - p3 - p4;
      sum_d = p1 - p4;
      sum_a = p2 - p3;
      abs_h = abs4(sum_h);
      abs_v = abs4(sum_v);
      abs_d = abs4(sum_d);
      abs_a = abs4(sum_a);
      g_h   = abs_h[2:1];
      g_v   = abs_v[2:1];
      g_d   = abs_d[1:0];
      g_a   = abs_a[1:0];
      g_hv  = (g_v > g_h) ? g_v : g_h;
      g_da  = (g_a > g_d) ? g_a : g_d;
      g_max = (g_da > g_hv) ? g_da : g_hv;
   end

   always_comb begin
      priority if (levels == 3'd1) begin
         symbol = mge_pkg::SYM_HASH;
      end else if (g_max == 2'd0) begin
         symbol = mge_pkg::SYM_SPACE;
      end else if (levels == 3'd2) begin
         symbol = mge_pkg::SYM_HASH;
      end else if (g_max == 2'd1) begin
         symbol = mge_pkg::SYM_DOT;
      end else if (levels == 3'd3) begin
         symbol = mge_pkg::SYM_HASH;
      end else if (g_max == 2'd2) begin
         symbol = mge_pkg::SYM_COLON;
      end else begin
         symbol = mge_pkg::SYM_HASH;
      end
   end

endmodule

@@ src/max_gradient_edge_to_symbols.sv @@
// Top level of the max-gradient edge-to-symbol converter
// Takes one grey pixel per clock in raster order unless stalled and returns
// one ASCII symbol for every pixel past the first row and first column of its
// image. Each pixel is clamped to grey_levels-1 and stored as two bits in a
// line buffer of MAX_WIDTH entries, a single-port read-first RAM that is read
// and written once per accepted pixel; that port sets the rate of one pixel
// per clock. Each pixel passes stage one, then its symbol the output register.
// The line buffer is never cleared, so pixels are taken right after reset.
// Write grey_levels and image_width only while the block is idle.
`include "assert_macros.svh"

module max_gradient_edge_to_symbols #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  mge_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output mge_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mge_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mge_pkg::IMAGE_WIDTH_BITS-1:0]   csr_data
);

   localparam int ADDR_WIDTH  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WIDTH_BITS  = ($clog2(MAX_WIDTH + 1) > mge_pkg::IMAGE_WIDTH_BITS)
                                ? $clog2(MAX_WIDTH + 1) : mge_pkg::IMAGE_WIDTH_BITS;
   localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_VAL = WIDTH_BITS'(MAX_WIDTH);
   localparam logic [WIDTH_BITS-1:0] MIN_WIDTH_VAL = WIDTH_BITS'(2);

   logic [mge_pkg::GREY_LEVELS_BITS-1:0] grey_levels_ff, grey_levels_in;
   logic [mge_pkg::IMAGE_WIDTH_BITS-1:0] image_width_ff, image_width_in;

   logic [ADDR_WIDTH-1:0]           col_ff, col_in;
   logic                            past_row_ff, past_row_in;
   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_emit_ff;
   logic                            s1_last_ff;
   logic [mge_pkg::LEVEL_BITS-1:0]  s1_px_ff;
   logic [mge_pkg::LEVEL_BITS-1:0]  left_ff;
   logic [mge_pkg::LEVEL_BITS-1:0]  upleft_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   mge_pkg::rsp_type                rsp_data_ff;

   logic [mge_pkg::GREY_LEVELS_BITS-1:0] levels;
   logic [mge_pkg::GREY_LEVELS_BITS-1:0] max_level;
   logic [mge_pkg::LEVEL_BITS-1:0]       px_clamped;
   logic [WIDTH_BITS-1:0]                width_raw, width_eff, col_next;
   logic [ADDR_WIDTH-1:0]                col_cur;
   logic                                 past_row_cur, last_cur, emit_cur;
   logic                                 accept, out_ready, s1_go, s1_free, load_rsp;
   logic [mge_pkg::LEVEL_BITS-1:0]       above;
   logic [mge_pkg::SYMBOL_BITS-1:0]      symbol;
   mge_pkg::window_type                  window;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      grey_levels_in = grey_levels_ff;
      image_width_in = image_width_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mge_pkg::CSR_GREY_LEVELS:
               grey_levels_in = csr_data[mge_pkg::GREY_LEVELS_BITS-1:0];
            mge_pkg::CSR_IMAGE_WIDTH:
               image_width_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (grey_levels_ff < mge_pkg::GREY_LEVELS_MIN) begin
         levels = mge_pkg::GREY_LEVELS_MIN;
      end else if (grey_levels_ff > mge_pkg::GREY_LEVELS_MAX) begin
         levels = mge_pkg::GREY_LEVELS_MAX;
      end else begin
         levels = grey_levels_ff;
      end
      max_level  = levels - 3'd1;
      px_clamped = (req_data.pixel > {5'b00000, max_level})
                   ? max_level[mge_pkg::LEVEL_BITS-1:0]
                   : req_data.pixel[mge_pkg::LEVEL_BITS-1:0];

      width_raw = WIDTH_BITS'(image_width_ff);
      if (width_raw < MIN_WIDTH_VAL) begin
         width_eff = MIN_WIDTH_VAL;
      end else if (width_raw > MAX_WIDTH_VAL) begin
         width_eff = MAX_WIDTH_VAL;
      end else begin
         width_eff = width_raw;
      end
   end

   // handshake
   always_comb begin
      out_ready = !rsp_valid_ff || !rsp_stall;
      s1_go     = s1_valid_ff && (!s1_emit_ff || out_ready);
      s1_free   = !s1_valid_ff || s1_go;
      accept    = req_valid && s1_free;
      load_rsp  = s1_go && s1_emit_ff;
   end

   assign req_stall = !s1_free;

   // column tracking and valid flags
   always_comb begin
      col_cur      = req_data.frame_start ? '0 : col_ff;
      past_row_cur = req_data.frame_start ? 1'b0 : past_row_ff;
      col_next     = WIDTH_BITS'(col_cur) + WIDTH_BITS'(1);
      last_cur     = (col_next >= width_eff);
      emit_cur     = past_row_cur && (col_cur != '0);

      col_in      = col_ff;
      past_row_in = past_row_ff;
      if (accept) begin
         col_in      = last_cur ? '0 : col_next[ADDR_WIDTH-1:0];
         past_row_in = past_row_cur || last_cur;
      end

      s1_valid_in = s1_valid_ff;
      if (s1_free) begin
         s1_valid_in = accept;
      end

      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in = load_rsp;
      end
   end

   mge_line_ram #(
      .DEPTH      (MAX_WIDTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .enable  (accept),
      .addr    (col_cur),
      .wr_data (px_clamped),
      .rd_data (above)
   );

   always_comb begin
      window.upper_left  = upleft_ff;
      window.upper_right = above;
      window.lower_left  = left_ff;
      window.lower_right = s1_px_ff;
   end

   mge_grad_core u_grad_core (
      .window (window),
      .levels (levels),
      .symbol (symbol)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         grey_levels_ff <= mge_pkg::GREY_LEVELS_RESET;
         image_width_ff <= mge_pkg::IMAGE_WIDTH_RESET;
         col_ff         <= '0;
         past_row_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         left_ff        <= '0;
         upleft_ff      <= '0;
      end else begin
         grey_levels_ff <= grey_levels_in;
         image_width_ff <= image_width_in;
         col_ff         <= col_in;
         past_row_ff    <= past_row_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (s1_go) begin
            left_ff   <= s1_px_ff;
            upleft_ff <= above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= px_clamped;
         s1_emit_ff <= emit_cur;
         s1_last_ff <= last_cur;
      end
      if (load_rsp && out_ready) begin
         rsp_data_ff.symbol  <= symbol;
         rsp_data_ff.row_end <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_IMPLIES(a_stall_only_when_full, clock, reset,
      req_stall |-> (s1_valid_ff && s1_emit_ff && rsp_valid_ff),
      "input stalled while pipeline has room")
   `ASSERT_IMPLIES(a_rsp_from_stage, clock, reset,
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_emit_ff),
      "result appeared without a window in stage one")
   `ASSERT_IMPLIES(a_symbol_legal, clock, reset,
      rsp_valid_ff |-> (rsp_data_ff.symbol == mge_pkg::SYM_SPACE ||
                        rsp_data_ff.symbol == mge_pkg::SYM_DOT ||
                        rsp_data_ff.symbol == mge_pkg::SYM_COLON ||
                        rsp_data_ff.symbol == mge_pkg::SYM_HASH),
      "illegal symbol code")

endmodule

@@ tb/max_gradient_edge_to_symbols_tb.sv @@
// Testbench for the max-gradient edge-to-symbol converter: directed and random images
module max_gradient_edge_to_symbols_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH       = 1024;
   localparam int DRAIN_CYCLES    = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_PIXELS   = 300;
   localparam int PIXEL_BITS      = mge_pkg::PIXEL_BITS;
   localparam int GREY_BITS       = mge_pkg::GREY_LEVELS_BITS;
   localparam int WIDTH_BITS      = mge_pkg::IMAGE_WIDTH_BITS;

   logic                                 clock     = 1'b0;
   logic                                 reset     = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   mge_pkg::req_type                     req_data  = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   mge_pkg::rsp_type                     rsp_data;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [mge_pkg::CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [WIDTH_BITS-1:0]                csr_data  = '0;

   int                          row_above [MAX_WIDTH] = '{default: 0};
   int                          left_level       = 0;
   int                          upper_left_level = 0;
   int                          column           = 0;
   bit                          below_first_row  = 1'b0;
   logic [GREY_BITS-1:0]        levels_reg = mge_pkg::GREY_LEVELS_RESET;
   logic [WIDTH_BITS-1:0]       width_reg  = mge_pkg::IMAGE_WIDTH_RESET;
   mge_pkg::rsp_type            expected_symbols [$];

   int mismatches    = 0;
   int pixels_sent   = 0;
   int quiet_cycles  = 0;
   bit steady        = 1'b0;
   int hold_requests = 0;
   int holds_done    = 0;
   int hold_left     = 0;

   max_gradient_edge_to_symbols DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int active_levels();
      if (levels_reg < mge_pkg::GREY_LEVELS_MIN) return int'(mge_pkg::GREY_LEVELS_MIN);
      if (levels_reg > mge_pkg::GREY_LEVELS_MAX) return int'(mge_pkg::GREY_LEVELS_MAX);
      return int'(levels_reg);
   endfunction

   function automatic int active_width();
      if (int'(width_reg) < 2) return 2;
      if (int'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
   endfunction

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic [mge_pkg::SYMBOL_BITS-1:0] gradient_symbol(input int g,
                                                                      input int levels);
      if (levels == 1 || g > 2 || (g == 2 && levels < 4) || (g == 1 && levels < 3))
         return mge_pkg::SYM_HASH;
      if (g == 0) return mge_pkg::SYM_SPACE;
      if (g == 1) return mge_pkg::SYM_DOT;
      return mge_pkg::SYM_COLON;
   endfunction

   function automatic logic [PIXEL_BITS-1:0] random_pixel();
      case ($urandom_range(9))
         0: return PIXEL_BITS'($urandom_range(255));
         1: return PIXEL_BITS'($urandom_range(3));
         default: return PIXEL_BITS'($urandom_range(active_levels() - 1));
      endcase
   endfunction

   task automatic predict_symbol(input mge_pkg::req_type item);
      int               levels;
      int               width;
      int               px;
      int               above;
      int               g;
      bit               last_col;
      mge_pkg::rsp_type sym;
      levels = active_levels();
      width  = active_width();
      px     = int'(item.pixel);
      if (px > levels - 1) px = levels - 1;
      if (item.frame_start) begin
         column          = 0;
         below_first_row = 1'b0;
      end
      above    = row_above[column];
      last_col = (column + 1 >= width);
      if (below_first_row && column > 0) begin
         g = magnitude(upper_left_level - above + left_level - px) / 2;
         if (magnitude(upper_left_level + above - left_level - px) / 2 > g)
            g = magnitude(upper_left_level + above - left_level - px) / 2;
         if (magnitude(upper_left_level - px) > g) g = magnitude(upper_left_level - px);
         if (magnitude(above - left_level) > g) g = magnitude(above - left_level);
         sym.symbol  = gradient_symbol(g, levels);
         sym.row_end = last_col;
         expected_symbols.push_back(sym);
      end
      upper_left_level  = above;
      row_above[column] = px;
      left_level        = px;
      if (last_col) begin
         column          = 0;
         below_first_row = 1'b1;
      end else begin
         column = column + 1;
      end
   endtask

   task automatic send_pixel(input logic [PIXEL_BITS-1:0] px, input logic fs);
      while (!steady && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= mge_pkg::req_type'{pixel: px, frame_start: fs};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_symbol(req_data);
      pixels_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input mge_pkg::csr_index_type idx,
                                 input logic [WIDTH_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == mge_pkg::CSR_GREY_LEVELS) levels_reg = value[GREY_BITS-1:0];
      else width_reg = value;
   endtask

   task automatic configure(input logic [WIDTH_BITS-1:0] levels_word,
                            input logic [WIDTH_BITS-1:0] width_word);
      wait_drained();
      write_register(mge_pkg::CSR_GREY_LEVELS, levels_word);
      write_register(mge_pkg::CSR_IMAGE_WIDTH, width_word);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_test_frame(input int width, input int rows, input int ramp_row);
      for (int r = 0; r < rows; r++)
         for (int c = 0; c < width; c++)
            send_pixel((r != ramp_row) ? '0 :
                       (c == width - 1) ? 8'd255 : PIXEL_BITS'(c), r == 0 && c == 0);
   endtask

   task automatic send_random_image(input int rows, input int extra,
                                    input bit new_frame, input bit noise);
      int total;
      total = rows * active_width() + extra;
      for (int n = 0; n < total; n++)
         send_pixel(random_pixel(), (n == 0 && new_frame) || (noise && $urandom_range(49) == 0));
   endtask

   task automatic test_symbol_map();
      configure(11'd4, 11'd4);
      send_test_frame(4, 2, 1);
      configure(11'd3, 11'd3);
      send_test_frame(3, 2, 1);
      configure(11'd2, 11'd2);
      send_test_frame(2, 2, -1);
      configure(11'd1, 11'd2);
      send_test_frame(2, 2, 1);
   endtask

   task automatic test_register_limits();
      configure(11'd0, 11'd0);
      send_test_frame(2, 2, 1);
      configure(11'd7, 11'd1);
      send_test_frame(2, 2, 1);
   endtask

   task automatic test_width_lowered_mid_row();
      configure(11'd4, 11'd4);
      send_test_frame(4, 1, -1);
      send_pixel(random_pixel(), 1'b0);
      send_pixel(random_pixel(), 1'b0);
      configure(11'd4, 11'd2);
      send_random_image(1, 1, 1'b0, 1'b0);
   endtask

   task automatic test_widest_image();
      configure(11'd4, 11'd2047);
      send_random_image(1, 3, 1'b1, 1'b0);
   endtask

   task automatic test_full_rate();
      configure(11'd4, 11'd8);
      steady = 1'b1;
      send_random_image(16, 0, 1'b1, 1'b0);
      wait_drained();
      steady = 1'b0;
   endtask

   task automatic test_output_hold_off();
      configure(11'd3, 11'd6);
      hold_requests++;
      send_random_image(10, 0, 1'b1, 1'b0);
   endtask

   task automatic test_drain_pause();
      configure(11'd4, 11'd5);
      send_random_image(2, 2, 1'b1, 1'b0);
      wait_drained();
      send_random_image(3, 0, 1'b0, 1'b0);
   endtask

   task automatic test_random_images();
      int                    target;
      int                    rows;
      logic [7:0]            junk;
      logic [GREY_BITS-1:0]  lv;
      logic [WIDTH_BITS-1:0] wd;
      target = pixels_sent + RANDOM_PIXELS;
      while (pixels_sent < target) begin
         lv   = ($urandom_range(4) == 0) ? GREY_BITS'($urandom_range(7))
                                         : GREY_BITS'($urandom_range(4, 1));
         junk = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : '0;
         case ($urandom_range(19))
            0: wd = WIDTH_BITS'($urandom_range(1));
            1: wd = WIDTH_BITS'($urandom_range(100, 25));
            default: wd = WIDTH_BITS'($urandom_range(24, 2));
         endcase
         configure({junk, lv}, wd);
         rows = (active_width() > 24) ? 2 : $urandom_range(6, 2);
         send_random_image(rows, $urandom_range(active_width() - 1), 1'b1, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      if (hold_requests != holds_done) begin
         holds_done = holds_done + 1;
         hold_left  = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 24);
      end
   end

   always @(posedge clock) begin
      mge_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_symbols.size() == 0) begin
            mismatches++;
            $display("%0t: symbol transfer expected none, actual %h row_end %b",
                     $time, rsp_data.symbol, rsp_data.row_end);
         end else begin
            want = expected_symbols.pop_front();
            if (rsp_data.symbol !== want.symbol) begin
               mismatches++;
               $display("%0t: symbol expected %h, actual %h",
                        $time, want.symbol, rsp_data.symbol);
            end
            if (rsp_data.row_end !== want.row_end) begin
               mismatches++;
               $display("%0t: row_end expected %b, actual %b",
                        $time, want.row_end, rsp_data.row_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_symbol_map();
      test_register_limits();
      test_width_lowered_mid_row();
      test_widest_image();
      test_full_rate();
      test_output_hold_off();
      test_drain_pause();
      test_random_images();
      wait_drained();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ max_gradient_edge_to_symbols.f @@
+incdir+src
src/mge_pkg.sv
src/mge_line_ram.sv
src/mge_grad_core.sv
src/max_gradient_edge_to_symbols.sv
tb/max_gradient_edge_to_symbols_tb.sv
